FILE: design/wzp_pkg.sv
// wzp_pkg: shared types and constants of the windowed zoom frame store
// request codes, register indexes, field widths, queue entry and zoom settings
// no dependencies
`default_nettype none

package wzp_pkg;

   // request kinds
   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_READ  = 1'b1;

   // register indexes of the configuration port
   localparam logic [2:0] CSR_ZOOM_FACTOR = 3'd0;
   localparam logic [2:0] CSR_CENTER_ROW  = 3'd1;
   localparam logic [2:0] CSR_CENTER_COL  = 3'd2;
   localparam logic [2:0] CSR_WIN_HEIGHT  = 3'd3;
   localparam logic [2:0] CSR_WIN_WIDTH   = 3'd4;
   localparam logic [2:0] CSR_FRAME_ROWS  = 3'd5;
   localparam logic [2:0] CSR_FRAME_COLS  = 3'd6;

   // field widths
   localparam int COORD_W    = 9;
   localparam int PIX_W      = 8;
   localparam int SIZE_W     = 10;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 10;

   // divider: numerator center*(zoom-1)+pos stays below 2^19
   localparam int NUM_W = 19;
   localparam int DEN_W = 10;

   // depth of the queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // one classified request
   typedef struct packed {
      logic               kind;
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] col;
      logic [PIX_W-1:0]   pix;
      logic               in_win;
      logic               in_store;
   } entry_type;

   // zoom settings used by the back end
   typedef struct packed {
      logic [SIZE_W-1:0]  zoom;
      logic [COORD_W-1:0] center_row;
      logic [COORD_W-1:0] center_col;
   } zoom_cfg_type;

endpackage

`default_nettype wire

FILE: design/window_zoom_pixel_replicate_core.sv
// window_zoom_pixel_replicate_core: top level of the windowed zoom frame store
// depends on wzp_pkg, wzp_front, wzp_queue and wzp_back
// A grey frame store of MAX_ROWS x MAX_COLS bytes with a nearest-neighbour zoom
// window. A write request stores req_pix_in at (req_pix_row, req_pix_col) and gives
// no response; a read request gives one response with the pixel at that position,
// taken from the zoomed window when the window fits the frame and the position lies
// in it (rsp_in_window high), otherwise the stored pixel itself. The front end
// classifies each request as it is accepted and places it in a two-entry queue; the
// back end drains the queue. Writes retire at one per clock while no read is in the
// back end. A read outside the window passes through queue pop, store read and result.
// A read inside the window passes through queue pop, then the source row and column
// (each a 19-step serial division by the zoom factor plus the hand-over), done one
// after the other on one divider, then store read and result. The result register
// frees the back end as soon as a response is loaded. The store has no reset: a
// position must be written before it is read. The user must write settings on the
// csr_ port only while no request is outstanding; the block does not enforce this.
`default_nettype none

module window_zoom_pixel_replicate_core
   import wzp_pkg::*;
#(
   parameter int MAX_ROWS = 512,
   parameter int MAX_COLS = 512
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic                  req_type,
   input  wire logic [COORD_W-1:0]    req_pix_row,
   input  wire logic [COORD_W-1:0]    req_pix_col,
   input  wire logic [PIX_W-1:0]      req_pix_in,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic      [PIX_W-1:0]      rsp_pix_out,
   output logic                       rsp_in_window
);

   localparam int FRW = $clog2(((MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS) + 1);

   logic           push, queue_full, queue_valid, queue_pop;
   entry_type      push_entry, queue_head;
   zoom_cfg_type   zoom_cfg;
   logic [FRW-1:0] frame_rows_eff, frame_cols_eff;

   // settings and request classification
   wzp_front #(
      .MAX_ROWS (MAX_ROWS),
      .MAX_COLS (MAX_COLS),
      .FRW      (FRW)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_type       (req_type),
      .req_pix_row    (req_pix_row),
      .req_pix_col    (req_pix_col),
      .req_pix_in     (req_pix_in),
      .push           (push),
      .push_entry     (push_entry),
      .queue_full     (queue_full),
      .zoom_cfg       (zoom_cfg),
      .frame_rows_eff (frame_rows_eff),
      .frame_cols_eff (frame_cols_eff)
   );

   // decoupling queue
   wzp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .not_empty  (queue_valid),
      .head       (queue_head),
      .pop        (queue_pop)
   );

   // execution against the frame store
   wzp_back #(
      .MAX_ROWS (MAX_ROWS),
      .MAX_COLS (MAX_COLS),
      .FRW      (FRW)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .zoom_cfg       (zoom_cfg),
      .frame_rows_eff (frame_rows_eff),
      .frame_cols_eff (frame_cols_eff),
      .queue_valid    (queue_valid),
      .queue_head     (queue_head),
      .queue_pop      (queue_pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_pix_out    (rsp_pix_out),
      .rsp_in_window  (rsp_in_window)
   );

endmodule

`default_nettype wire

FILE: design/wzp_ram.sv
// wzp_ram: generic single-write, single-read memory with registered read data
// no dependencies
`default_nettype none

module wzp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // read port, data held until the next read
   always_ff @(posedge clock) begin
      if (re) begin
         rdata <= mem[raddr];
      end
   end

endmodule

`default_nettype wire

FILE: design/wzp_div.sv
// wzp_div: restoring divider, one quotient bit per cycle
// depends on wzp_pkg for the numerator and denominator widths
`default_nettype none

module wzp_div
   import wzp_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [NUM_W-1:0] num,
   input  wire logic [DEN_W-1:0] den,
   output logic      [NUM_W-1:0] quo,
   output logic                  done
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DEN_W:0]   trial;
   logic             fits;

   // one shift-and-subtract step
   always_comb begin
      trial   = {rem_ff, quo_ff[NUM_W-1]};
      fits    = trial >= {1'b0, den};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = num;
         rem_in  = '0;
         cnt_in  = CNT_W'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[NUM_W-2:0], fits};
         rem_in = fits ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
   end

   assign quo  = quo_ff;
   assign done = done_ff;

endmodule

`default_nettype wire

FILE: design/wzp_queue.sv
// wzp_queue: short request queue between the front and the back end
// depends on wzp_pkg for the entry type and depth
`default_nettype none

module wzp_queue
   import wzp_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      push,
   input  wire entry_type push_entry,
   output logic           full,
   output logic           not_empty,
   output entry_type      head,
   input  wire logic      pop
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   entry_type        slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      begin
         next_ptr = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
      end
   endfunction

   assign full      = count_ff == CNT_W'(QUEUE_DEPTH);
   assign not_empty = count_ff != '0;
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign head      = slot_ff[rd_ptr_ff];

   // pointers and fill level
   always_comb begin
      wr_ptr_in = do_push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

FILE: design/wzp_front.sv
// wzp_front: configuration registers and request classification
// decides window membership and store range before a request is queued
// depends on wzp_pkg
`default_nettype none

module wzp_front
   import wzp_pkg::*;
#(
   parameter int MAX_ROWS = 512,
   parameter int MAX_COLS = 512,
   parameter int FRW      = 10
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic                  req_type,
   input  wire logic [COORD_W-1:0]    req_pix_row,
   input  wire logic [COORD_W-1:0]    req_pix_col,
   input  wire logic [PIX_W-1:0]      req_pix_in,
   output logic                       push,
   output entry_type                  push_entry,
   input  wire logic                  queue_full,
   output zoom_cfg_type               zoom_cfg,
   output logic      [FRW-1:0]        frame_rows_eff,
   output logic      [FRW-1:0]        frame_cols_eff
);

   // compare width: covers center plus size and the largest frame
   localparam int CW = (FRW > 11) ? FRW + 1 : 12;

   logic [SIZE_W-1:0]  zoom_factor_ff;
   logic [COORD_W-1:0] center_row_ff;
   logic [COORD_W-1:0] center_col_ff;
   logic [SIZE_W-1:0]  win_height_ff;
   logic [SIZE_W-1:0]  win_width_ff;
   logic [SIZE_W-1:0]  frame_rows_ff;
   logic [SIZE_W-1:0]  frame_cols_ff;
   logic               row_inside, col_inside, in_store;

   // frame size limited to 1..max
   function automatic logic [FRW-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                  input logic [CW-1:0] maxv);
      logic [CW-1:0] w;
      begin
         w = CW'(v);
         if (w == '0) begin
            clamp_size = FRW'(1);
         end else if (w > maxv) begin
            clamp_size = FRW'(maxv);
         end else begin
            clamp_size = FRW'(w);
         end
      end
   endfunction

   // window fits the frame along one axis and pos lies within it
   function automatic logic axis_inside(input logic [COORD_W-1:0] center,
                                        input logic [SIZE_W-1:0]  size,
                                        input logic [FRW-1:0]     frame,
                                        input logic [COORD_W-1:0] pos);
      logic [CW-1:0] c, h, s, p, f;
      begin
         c = CW'(center);
         h = CW'(size >> 1);
         s = CW'(size);
         p = CW'(pos);
         f = CW'(frame);
         axis_inside = (c >= h) && (c + h <= f) && (p + h >= c) &&
                       (p + h < c + s) && (p < f);
      end
   endfunction

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         zoom_factor_ff <= SIZE_W'(1);
         center_row_ff  <= '0;
         center_col_ff  <= '0;
         win_height_ff  <= '0;
         win_width_ff   <= '0;
         frame_rows_ff  <= SIZE_W'(512);
         frame_cols_ff  <= SIZE_W'(512);
      end else if (csr_we) begin
         case (csr_index)
            CSR_ZOOM_FACTOR: zoom_factor_ff <= csr_wdata;
            CSR_CENTER_ROW:  center_row_ff  <= csr_wdata[COORD_W-1:0];
            CSR_CENTER_COL:  center_col_ff  <= csr_wdata[COORD_W-1:0];
            CSR_WIN_HEIGHT:  win_height_ff  <= csr_wdata;
            CSR_WIN_WIDTH:   win_width_ff   <= csr_wdata;
            CSR_FRAME_ROWS:  frame_rows_ff  <= csr_wdata;
            CSR_FRAME_COLS:  frame_cols_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // effective settings
   assign frame_rows_eff      = clamp_size(frame_rows_ff, CW'(MAX_ROWS));
   assign frame_cols_eff      = clamp_size(frame_cols_ff, CW'(MAX_COLS));
   assign zoom_cfg.zoom       = (zoom_factor_ff == '0) ? SIZE_W'(1) : zoom_factor_ff;
   assign zoom_cfg.center_row = center_row_ff;
   assign zoom_cfg.center_col = center_col_ff;

   // classification of the incoming request
   assign row_inside = axis_inside(center_row_ff, win_height_ff, frame_rows_eff,
                                   req_pix_row);
   assign col_inside = axis_inside(center_col_ff, win_width_ff, frame_cols_eff,
                                   req_pix_col);
   assign in_store   = (CW'(req_pix_row) < CW'(MAX_ROWS)) &&
                       (CW'(req_pix_col) < CW'(MAX_COLS));

   assign push_entry.kind     = req_type;
   assign push_entry.row      = req_pix_row;
   assign push_entry.col      = req_pix_col;
   assign push_entry.pix      = req_pix_in;
   assign push_entry.in_win   = row_inside && col_inside;
   assign push_entry.in_store = in_store;

   // handshake towards the queue
   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

endmodule

`default_nettype wire

FILE: design/wzp_back.sv
// wzp_back: executes queued requests against the frame store
// source position by serial division, store access and result register
// depends on wzp_pkg, wzp_div and wzp_ram
`default_nettype none

module wzp_back
   import wzp_pkg::*;
#(
   parameter int MAX_ROWS = 512,
   parameter int MAX_COLS = 512,
   parameter int FRW      = 10
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire zoom_cfg_type       zoom_cfg,
   input  wire logic [FRW-1:0]     frame_rows_eff,
   input  wire logic [FRW-1:0]     frame_cols_eff,
   input  wire logic               queue_valid,
   input  wire entry_type          queue_head,
   output logic                    queue_pop,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic      [PIX_W-1:0]   rsp_pix_out,
   output logic                    rsp_in_window
);

   localparam int DEPTH = MAX_ROWS * MAX_COLS;
   localparam int AW    = $clog2(DEPTH);
   localparam int SW    = (FRW > COORD_W) ? FRW : COORD_W;

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_DROW  = 5'b00010,
      S_DCOL  = 5'b00100,
      S_FETCH = 5'b01000,
      S_DATA  = 5'b10000
   } state_type;

   state_type          state_ff, state_in;
   logic [COORD_W-1:0] src_row_ff, src_row_in;
   logic [COORD_W-1:0] src_col_ff, src_col_in;
   logic               in_win_ff, in_win_in;
   logic               in_store_ff, in_store_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [PIX_W-1:0]   rsp_pix_ff;
   logic               rsp_win_ff;
   logic               rsp_load;

   logic [COORD_W-1:0] num_center, num_pos;
   logic [SIZE_W-1:0]  zoom_m1;
   logic [NUM_W-1:0]   num_prod, div_num, div_quo;
   logic               div_start, div_done;

   logic               ram_we, ram_re;
   logic [AW-1:0]      ram_waddr, ram_raddr;
   logic [PIX_W-1:0]   ram_rdata;

   function automatic logic [AW-1:0] store_addr(input logic [COORD_W-1:0] r,
                                                input logic [COORD_W-1:0] c);
      begin
         store_addr = AW'(r) * AW'(MAX_COLS) + AW'(c);
      end
   endfunction

   // source index limited to the last row or column of the frame
   function automatic logic [COORD_W-1:0] clamp_src(input logic [NUM_W-1:0] q,
                                                    input logic [FRW-1:0] frame);
      logic [SW-1:0] qs, fs;
      begin
         qs = SW'(q[COORD_W-1:0]);
         fs = SW'(frame);
         if (qs >= fs) begin
            clamp_src = COORD_W'(fs - SW'(1));
         end else begin
            clamp_src = q[COORD_W-1:0];
         end
      end
   endfunction

   // numerator center*(zoom-1)+pos for the axis being started
   assign zoom_m1  = zoom_cfg.zoom - SIZE_W'(1);
   assign num_prod = NUM_W'(num_center) * NUM_W'(zoom_m1);
   assign div_num  = num_prod + NUM_W'(num_pos);

   wzp_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (zoom_cfg.zoom),
      .quo   (div_quo),
      .done  (div_done)
   );

   // frame store
   assign ram_waddr = store_addr(queue_head.row, queue_head.col);
   assign ram_raddr = store_addr(src_row_ff, src_col_ff);

   wzp_ram #(
      .WIDTH (PIX_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (queue_head.pix),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // request sequencer
   always_comb begin
      state_in    = state_ff;
      src_row_in  = src_row_ff;
      src_col_in  = src_col_ff;
      in_win_in   = in_win_ff;
      in_store_in = in_store_ff;
      queue_pop   = 1'b0;
      ram_we      = 1'b0;
      ram_re      = 1'b0;
      div_start   = 1'b0;
      rsp_load    = 1'b0;
      num_center  = zoom_cfg.center_row;
      num_pos     = queue_head.row;
      case (state_ff)
         S_IDLE: begin
            if (queue_valid) begin
               queue_pop = 1'b1;
               if (queue_head.kind == REQ_WRITE) begin
                  ram_we = queue_head.in_store;
               end else begin
                  src_row_in  = queue_head.row;
                  src_col_in  = queue_head.col;
                  in_win_in   = queue_head.in_win;
                  in_store_in = queue_head.in_store;
                  if (queue_head.in_win) begin
                     div_start = 1'b1;
                     state_in  = S_DROW;
                  end else begin
                     state_in = S_FETCH;
                  end
               end
            end
         end
         S_DROW: begin
            num_center = zoom_cfg.center_col;
            num_pos    = src_col_ff;
            if (div_done) begin
               src_row_in = clamp_src(div_quo, frame_rows_eff);
               div_start  = 1'b1;
               state_in   = S_DCOL;
            end
         end
         S_DCOL: begin
            if (div_done) begin
               src_col_in = clamp_src(div_quo, frame_cols_eff);
               state_in   = S_FETCH;
            end
         end
         S_FETCH: begin
            ram_re   = 1'b1;
            state_in = S_DATA;
         end
         S_DATA: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working registers and result register
   always_ff @(posedge clock) begin
      src_row_ff  <= src_row_in;
      src_col_ff  <= src_col_in;
      in_win_ff   <= in_win_in;
      in_store_ff <= in_store_in;
      if (rsp_load) begin
         rsp_pix_ff <= in_store_ff ? ram_rdata : '0;
         rsp_win_ff <= in_win_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_pix_out   = rsp_pix_ff;
   assign rsp_in_window = rsp_win_ff;

endmodule

`default_nettype wire

FILE: test/wzp_checker.sv
`timescale 1ns / 100ps
// wzp_checker: watches the csr, request and response ports of the windowed zoom frame store
// keeps its own copy of the settings and the pixel store, predicts every read and compares
// depends on wzp_pkg only

module wzp_checker
   import wzp_pkg::*;
#(
   parameter int MAX_ROWS = 512,
   parameter int MAX_COLS = 512
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  logic                  req_type,
   input  logic [COORD_W-1:0]    req_pix_row,
   input  logic [COORD_W-1:0]    req_pix_col,
   input  logic [PIX_W-1:0]      req_pix_in,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  logic [PIX_W-1:0]      rsp_pix_out,
   input  logic                  rsp_in_window,
   output int                    fail_count,
   output int                    pending
);

   // one predicted read response
   typedef struct packed {
      logic [PIX_W-1:0] pix;
      logic             in_win;
   } zoom_pixel_type;

   logic [PIX_W-1:0]   frame_mem [0:MAX_ROWS*MAX_COLS-1];
   logic [SIZE_W-1:0]  zoom_q;
   logic [COORD_W-1:0] center_row_q;
   logic [COORD_W-1:0] center_col_q;
   logic [SIZE_W-1:0]  win_height_q;
   logic [SIZE_W-1:0]  win_width_q;
   logic [SIZE_W-1:0]  frame_rows_q;
   logic [SIZE_W-1:0]  frame_cols_q;
   zoom_pixel_type     expected_pixels [$];

   // frame size as used: at least one, at most the store
   function automatic int clamp_frame(input int size, input int limit);
      if (size < 1) return 1;
      if (size > limit) return limit;
      return size;
   endfunction

   // window fits the frame on this axis and the position lies within it
   function automatic bit fits_axis(input int center, input int size, input int frame,
                                    input int pos);
      int lo, hi;
      lo = center - size / 2;
      hi = center + size / 2;
      if (lo < 0 || hi > frame) return 1'b0;
      if (pos < lo || pos >= lo + size) return 1'b0;
      return pos < frame;
   endfunction

   // replicated source line, held inside the frame
   function automatic int unsigned source_line(input int unsigned center,
                                               input int unsigned pos,
                                               input int unsigned zoom,
                                               input int unsigned frame);
      int unsigned s;
      s = (center * (zoom - 1) + pos) / zoom;
      return (s >= frame) ? frame - 1 : s;
   endfunction

   function automatic zoom_pixel_type predict_pixel(input int unsigned row,
                                                    input int unsigned col);
      int unsigned rows, cols, zoom, src_row, src_col;
      zoom_pixel_type res;
      rows = clamp_frame(frame_rows_q, MAX_ROWS);
      cols = clamp_frame(frame_cols_q, MAX_COLS);
      zoom = (zoom_q == 0) ? 1 : zoom_q;
      src_row = row;
      src_col = col;
      res.in_win = fits_axis(center_row_q, win_height_q, rows, row) &&
                   fits_axis(center_col_q, win_width_q, cols, col);
      if (res.in_win) begin
         src_row = source_line(center_row_q, row, zoom, rows);
         src_col = source_line(center_col_q, col, zoom, cols);
      end
      if (src_row >= MAX_ROWS || src_col >= MAX_COLS) res.pix = '0;
      else res.pix = frame_mem[src_row * MAX_COLS + src_col];
      return res;
   endfunction

   // sample every port at the clock edge
   always @(posedge clock) begin : watch
      zoom_pixel_type want;
      int errs;
      errs = 0;
      if (reset) begin
         zoom_q       <= SIZE_W'(1);
         center_row_q <= '0;
         center_col_q <= '0;
         win_height_q <= '0;
         win_width_q  <= '0;
         frame_rows_q <= SIZE_W'(512);
         frame_cols_q <= SIZE_W'(512);
         expected_pixels.delete();
         fail_count   <= 0;
         pending      <= 0;
      end else begin
         // responses before requests, so a response never meets its own request
         if (rsp_valid && !rsp_stall) begin
            if (expected_pixels.size() == 0) begin
               $error("pix_out: no read outstanding, expected none, got %0d", rsp_pix_out);
               errs++;
            end else begin
               want = expected_pixels.pop_front();
               if (rsp_pix_out !== want.pix) begin
                  $error("pix_out: expected %0d, got %0d", want.pix, rsp_pix_out);
                  errs++;
               end
               if (rsp_in_window !== want.in_win) begin
                  $error("in_window: expected %0d, got %0d", want.in_win, rsp_in_window);
                  errs++;
               end
            end
         end

         // accepted request: store a pixel or predict a read
         if (req_valid && !req_stall) begin
            if (req_type == REQ_READ)
               expected_pixels.push_back(predict_pixel(req_pix_row, req_pix_col));
            else if (req_pix_row < MAX_ROWS && req_pix_col < MAX_COLS)
               frame_mem[req_pix_row * MAX_COLS + req_pix_col] = req_pix_in;
         end

         // settings mirror, unknown indexes ignored
         if (csr_we) begin
            case (csr_index)
               CSR_ZOOM_FACTOR: zoom_q       <= csr_wdata;
               CSR_CENTER_ROW:  center_row_q <= csr_wdata[COORD_W-1:0];
               CSR_CENTER_COL:  center_col_q <= csr_wdata[COORD_W-1:0];
               CSR_WIN_HEIGHT:  win_height_q <= csr_wdata;
               CSR_WIN_WIDTH:   win_width_q  <= csr_wdata;
               CSR_FRAME_ROWS:  frame_rows_q <= csr_wdata;
               CSR_FRAME_COLS:  frame_cols_q <= csr_wdata;
               default: ;
            endcase
         end

         fail_count <= fail_count + errs;
         pending    <= expected_pixels.size();
      end
   end

endmodule

FILE: test/tb_window_zoom_pixel_replicate_core.sv
`timescale 1ns / 100ps
// tb_window_zoom_pixel_replicate_core: stimulus, settings phases and verdict for the zoom store
// depends on wzp_pkg, window_zoom_pixel_replicate_core and wzp_checker

module tb_window_zoom_pixel_replicate_core;
   import wzp_pkg::*;

   localparam int MAX_ROWS       = 512;
   localparam int MAX_COLS       = 512;
   localparam int CYCLE_LIMIT    = 1000000;
   localparam int SETTLE_CYCLES  = 60;
   localparam int PHASES         = 9;
   localparam int PHASE_REQUESTS = 125;
   localparam int COORD_MAX      = (1 << COORD_W) - 1;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 3'd7;

   logic                  clock         = 1'b0;
   logic                  reset         = 1'b1;
   logic                  csr_we        = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index     = '0;
   logic [CSR_DATA_W-1:0] csr_wdata     = '0;
   logic                  req_valid     = 1'b0;
   logic                  req_type      = REQ_WRITE;
   logic [COORD_W-1:0]    req_pix_row   = '0;
   logic [COORD_W-1:0]    req_pix_col   = '0;
   logic [PIX_W-1:0]      req_pix_in    = '0;
   logic                  rsp_stall     = 1'b0;
   logic                  req_stall;
   logic                  rsp_valid;
   logic [PIX_W-1:0]      rsp_pix_out;
   logic                  rsp_in_window;
   int                    fail_count;
   int                    pending;
   int unsigned           cycle_count   = 0;
   int                    send_idle_pct = 0;
   int                    recv_idle_pct = 0;

   // positions written so far; reads only go where the store holds data
   bit                    stored [0:MAX_ROWS*MAX_COLS-1];
   int unsigned           stored_list [$];

   // settings as last written, centres already masked to their width
   int unsigned set_zoom = 1, set_crow = 0, set_ccol = 0, set_wh = 0, set_ww = 0;

   window_zoom_pixel_replicate_core #(
      .MAX_ROWS(MAX_ROWS),
      .MAX_COLS(MAX_COLS)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_type(req_type),
      .req_pix_row(req_pix_row),
      .req_pix_col(req_pix_col),
      .req_pix_in(req_pix_in),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_pix_out(rsp_pix_out),
      .rsp_in_window(rsp_in_window)
   );

   wzp_checker #(
      .MAX_ROWS(MAX_ROWS),
      .MAX_COLS(MAX_COLS)
   ) i_checker (
      .clock(clock),
      .reset(reset),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_type(req_type),
      .req_pix_row(req_pix_row),
      .req_pix_col(req_pix_col),
      .req_pix_in(req_pix_in),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_pix_out(rsp_pix_out),
      .rsp_in_window(rsp_in_window),
      .fail_count(fail_count),
      .pending(pending)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // response back-pressure and the run limit
   always @(posedge clock) begin
      rsp_stall   <= ($urandom_range(99) < recv_idle_pct);
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   function automatic int least(input int a, input int b);
      return (a < b) ? a : b;
   endfunction

   function automatic int clamp_frame(input int size, input int limit);
      if (size < 1) return 1;
      if (size > limit) return limit;
      return size;
   endfunction

   // lines a zoomed read may fetch on one axis; false when nothing needs filling
   function automatic bit source_span(input int center, input int size, input int frame,
                                      input int zoom, input int last,
                                      output int lo, output int hi);
      lo = center - (size / 2 + zoom - 1) / zoom;
      hi = center + (size - size / 2 - 1) / zoom;
      if (lo < 0) lo = 0;
      if (hi > last) hi = last;
      return size > 0 && zoom > 1 && center - size / 2 >= 0 && center + size / 2 <= frame;
   endfunction

   function automatic int unsigned random_frame();
      case ($urandom_range(9))
         0: return 0;
         1: return $urandom_range(1023, 513);
         2, 3, 4: return $urandom_range(512, 1);
         default: return $urandom_range(64, 1);
      endcase
   endfunction

   // mostly windows that fit, sized so replication spans only a few source lines
   function automatic void random_window(input int frame, input int zoom,
                                         output int unsigned centre, output int unsigned size);
      centre = $urandom_range(least(frame, COORD_MAX));
      if ($urandom_range(99) < 15)
         size = $urandom_range(1023);
      else
         size = $urandom_range(least(least(2 * centre + 1, 2 * (frame - centre) + 1),
                                     6 * zoom));
   endfunction

   // position biased into the current window
   function automatic void pick_position(output int unsigned row, output int unsigned col);
      int r, c;
      if (set_wh != 0 && set_ww != 0 && $urandom_range(9) < 7) begin
         r = int'(set_crow) - int'(set_wh / 2) + int'($urandom_range(set_wh - 1));
         c = int'(set_ccol) - int'(set_ww / 2) + int'($urandom_range(set_ww - 1));
         row = (r < 0) ? 0 : (r > MAX_ROWS - 1) ? MAX_ROWS - 1 : r;
         col = (c < 0) ? 0 : (c > MAX_COLS - 1) ? MAX_COLS - 1 : c;
      end else begin
         row = $urandom_range(MAX_ROWS - 1);
         col = $urandom_range(MAX_COLS - 1);
      end
   endfunction

   // one request: optional idle gap, then hold until accepted
   task automatic send_request(input logic kind, input int unsigned row,
                               input int unsigned col, input int unsigned pix);
      int unsigned addr;
      addr = row * MAX_COLS + col;
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid   <= 1'b1;
      req_type    <= kind;
      req_pix_row <= row[COORD_W-1:0];
      req_pix_col <= col[COORD_W-1:0];
      req_pix_in  <= pix[PIX_W-1:0];
      do @(posedge clock); while (req_stall);
      if (kind == REQ_WRITE && !stored[addr]) begin
         stored[addr] = 1'b1;
         stored_list.push_back(addr);
      end
   endtask

   // stop sending, wait for every read to answer, then let queued writes retire
   task automatic drain_block();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   // write all registers while idle, then make sure zoomed reads find data
   task automatic apply_settings(input int unsigned zoom, input int unsigned crow,
                                 input int unsigned ccol, input int unsigned wh,
                                 input int unsigned ww, input int unsigned fr,
                                 input int unsigned fc);
      int rows, cols, zeff, r_lo, r_hi, c_lo, c_hi;
      set_zoom = zoom & 10'h3FF;
      set_crow = crow & COORD_MAX;
      set_ccol = ccol & COORD_MAX;
      set_wh   = wh & 10'h3FF;
      set_ww   = ww & 10'h3FF;
      rows = clamp_frame(fr & 10'h3FF, MAX_ROWS);
      cols = clamp_frame(fc & 10'h3FF, MAX_COLS);
      zeff = (set_zoom == 0) ? 1 : set_zoom;
      csr_write(CSR_SPARE, CSR_DATA_W'($urandom));
      csr_write(CSR_ZOOM_FACTOR, zoom[CSR_DATA_W-1:0]);
      // the spare top bit of a centre must be dropped
      csr_write(CSR_CENTER_ROW, {1'($urandom_range(1)), crow[COORD_W-1:0]});
      csr_write(CSR_CENTER_COL, {1'($urandom_range(1)), ccol[COORD_W-1:0]});
      csr_write(CSR_WIN_HEIGHT, wh[CSR_DATA_W-1:0]);
      csr_write(CSR_WIN_WIDTH, ww[CSR_DATA_W-1:0]);
      csr_write(CSR_FRAME_ROWS, fr[CSR_DATA_W-1:0]);
      csr_write(CSR_FRAME_COLS, fc[CSR_DATA_W-1:0]);
      csr_we <= 1'b0;
      @(posedge clock);
      if (source_span(set_crow, set_wh, rows, zeff, MAX_ROWS - 1, r_lo, r_hi) &&
          source_span(set_ccol, set_ww, cols, zeff, MAX_COLS - 1, c_lo, c_hi)) begin
         for (int r = r_lo; r <= r_hi; r++)
            for (int c = c_lo; c <= c_hi; c++)
               if (!stored[r * MAX_COLS + c])
                  send_request(REQ_WRITE, r, c, $urandom_range(255));
      end
   endtask

   initial begin : stimulus
      int unsigned zoom, fr, fc, crow, ccol, wh, ww, row, col, addr;
      int zeff;

      send_idle_pct = 20;
      recv_idle_pct <= 86;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // corners and a middle pixel under reset settings: empty window, full frame
      send_request(REQ_WRITE, 0, 0, 8'h00);
      send_request(REQ_WRITE, MAX_ROWS - 1, MAX_COLS - 1, 8'hFF);
      send_request(REQ_WRITE, 0, MAX_COLS - 1, 8'hAA);
      send_request(REQ_WRITE, MAX_ROWS - 1, 0, 8'h55);
      send_request(REQ_WRITE, 255, 256, 8'h81);
      send_request(REQ_READ, 0, 0, 8'hFF);
      send_request(REQ_READ, MAX_ROWS - 1, MAX_COLS - 1, 8'h00);
      send_request(REQ_READ, 0, MAX_COLS - 1, 8'h5A);
      send_request(REQ_READ, MAX_ROWS - 1, 0, 8'hA5);
      send_request(REQ_READ, 255, 256, 8'h7E);
      drain_block();

      // zoom of four around (8, 8) in a 16 x 16 frame; reads inside, outside and past the frame
      apply_settings(4, 8, 8, 8, 8, 16, 16);
      send_request(REQ_WRITE, 4, 4, 8'h3C);
      send_request(REQ_WRITE, 11, 11, 8'hC3);
      send_request(REQ_READ, 4, 4, 8'h00);
      send_request(REQ_READ, 11, 11, 8'h00);
      send_request(REQ_READ, 8, 8, 8'h00);
      send_request(REQ_READ, MAX_ROWS - 1, MAX_COLS - 1, 8'h00);
      send_request(REQ_READ, 0, 0, 8'h00);
      drain_block();

      // zero zoom, frame rows below range, frame columns above range, one pixel window
      apply_settings(0, 0, 0, 1, 1, 0, 1023);
      send_request(REQ_READ, 0, 0, 8'h00);
      send_request(REQ_READ, 0, MAX_COLS - 1, 8'h00);
      send_request(REQ_READ, MAX_ROWS - 1, MAX_COLS - 1, 8'h00);
      drain_block();

      for (int phase = 0; phase < PHASES; phase++) begin
         // idling: receiver-heavy, then sender-heavy, then none
         if (phase == PHASES / 3) begin
            send_idle_pct = 86;
            recv_idle_pct <= 20;
         end else if (phase == 2 * PHASES / 3) begin
            send_idle_pct = 0;
            recv_idle_pct <= 0;
         end

         case (phase)
            // whole frame as window at a zoom of 512
            0: apply_settings(512, 256, 256, 512, 512, 512, 512);
            // largest zoom, window in the far corner, oversized frame registers
            1: apply_settings(1023, 511, 511, 2, 2, 1023, 1023);
            // window far too tall: never fits
            2: apply_settings(0, 0, 511, 1023, 1, 0, 1023);
            // unit zoom inside a fitting window
            3: apply_settings(1, 256, 100, 512, 200, 512, 300);
            default: begin
               case ($urandom_range(9))
                  0: zoom = 0;
                  1: zoom = $urandom_range(1023, 513);
                  default: zoom = $urandom_range(16, 1);
               endcase
               zeff = (zoom == 0) ? 1 : zoom;
               fr = random_frame();
               fc = random_frame();
               random_window(clamp_frame(fr, MAX_ROWS), zeff, crow, wh);
               random_window(clamp_frame(fc, MAX_COLS), zeff, ccol, ww);
               apply_settings(zoom, crow, ccol, wh, ww, fr, fc);
            end
         endcase

         // random mix of writes and reads of written positions
         for (int n = 0; n < PHASE_REQUESTS; n++) begin
            pick_position(row, col);
            if ($urandom_range(99) < 45 || stored_list.size() == 0) begin
               send_request(REQ_WRITE, row, col, $urandom_range(255));
            end else begin
               if (!stored[row * MAX_COLS + col]) begin
                  addr = stored_list[$urandom_range(stored_list.size() - 1)];
                  row  = addr / MAX_COLS;
                  col  = addr % MAX_COLS;
               end
               send_request(REQ_READ, row, col, $urandom_range(255));
            end
         end
         drain_block();
      end

      if (fail_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

FILE: sim.f
design/wzp_pkg.sv
design/wzp_ram.sv
design/wzp_div.sv
design/wzp_queue.sv
design/wzp_front.sv
design/wzp_back.sv
design/window_zoom_pixel_replicate_core.sv
test/wzp_checker.sv
test/tb_window_zoom_pixel_replicate_core.sv
